// ----- rtl/core/tdp_pkg.sv -----
`timescale 1ns / 1ps
package tdp_pkg;

  localparam int unsigned PAGE_W           = 52;
  localparam int unsigned DIST_W           = 53;
  localparam int unsigned DATA_W           = 56;
  localparam int unsigned NUM_SETS_DEF     = 64;
  localparam int unsigned NUM_WAYS_DEF     = 4;
  localparam int unsigned PAGE_OFF_DEF     = 12;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_WAITQ,
    ST_RD_CUR,
    ST_LOOK_CUR,
    ST_RD_PRIOR,
    ST_LOOK_PRIOR
  } state_e;

  typedef struct packed {
    logic in_ready;
    logic clr_step;
    logic mod_step;
    logic rd_cur;
    logic look_cur;
    logic rd_prior;
    logic look_prior;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_hit;
    logic prior_page_valid;
    logic prior_dist_valid;
    logic mod_done;
    logic clr_done;
    logic q_empty;
  } status_t;

endpackage

// ----- rtl/core/tdp_ram.sv -----
`timescale 1ns / 1ps
module tdp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ----- rtl/core/tdp_ctrl.sv -----
`timescale 1ns / 1ps
module tdp_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tdp_pkg::status_t status_i,
  output tdp_pkg::cmd_t    cmd_o
);
  import tdp_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (status_i.clr_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (status_i.in_valid && !status_i.in_hit && status_i.prior_page_valid) begin
          state_d = ST_MOD;
        end
      end
      ST_MOD: begin
        if (status_i.mod_done) state_d = ST_WAITQ;
      end
      ST_WAITQ: begin
        if (status_i.q_empty) state_d = ST_RD_CUR;
      end
      ST_RD_CUR:   state_d = ST_LOOK_CUR;
      ST_LOOK_CUR: state_d = status_i.prior_dist_valid ? ST_RD_PRIOR : ST_IDLE;
      ST_RD_PRIOR: state_d = ST_LOOK_PRIOR;
      ST_LOOK_PRIOR: state_d = ST_IDLE;
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_CLEAR:      cmd_o.clr_step   = 1'b1;
      ST_IDLE:       cmd_o.in_ready   = 1'b1;
      ST_MOD:        cmd_o.mod_step   = 1'b1;
      ST_WAITQ:      cmd_o = '0;
      ST_RD_CUR:     cmd_o.rd_cur     = 1'b1;
      ST_LOOK_CUR:   cmd_o.look_cur   = 1'b1;
      ST_RD_PRIOR:   cmd_o.rd_prior   = 1'b1;
      ST_LOOK_PRIOR: cmd_o.look_prior = 1'b1;
      default:       cmd_o = '0;
    endcase
  end

endmodule

// ----- rtl/core/tdp_datapath.sv -----
`timescale 1ns / 1ps
module tdp_datapath #(
  parameter int unsigned NUM_SETS         = tdp_pkg::NUM_SETS_DEF,
  parameter int unsigned NUM_WAYS         = tdp_pkg::NUM_WAYS_DEF,
  parameter int unsigned PAGE_OFFSET_BITS = tdp_pkg::PAGE_OFF_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tdp_pkg::cmd_t               cmd_i,
  output tdp_pkg::status_t            status_o,
  input  logic                        in_valid_i,
  input  logic [tdp_pkg::PAGE_W-1:0]  in_page_i,
  input  logic                        in_hit_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [tdp_pkg::PAGE_W-1:0]  out_page_o,
  output logic                        out_last_o
);
  import tdp_pkg::*;

  localparam int unsigned IW   = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int unsigned RW   = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int unsigned WW   = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam bit          POW2 = ((NUM_SETS & (NUM_SETS - 1)) == 0);
  localparam logic [PAGE_W+1:0] MAX_PAGE =
      ((PAGE_W+2)'(1) << (64 - PAGE_OFFSET_BITS)) - (PAGE_W+2)'(1);
  localparam int unsigned DG   = 8;
  localparam int unsigned NDIG = 64 / DG;
  localparam int unsigned CW   = $clog2(NDIG);
  localparam int unsigned XW   = IW + DG;
  localparam logic [XW-1:0] RECIP = XW'((64'd1 << XW) / 64'(NUM_SETS));

  typedef struct packed {
    logic                   valid;
    logic [DIST_W-1:0]      distance;
    logic [RW-1:0]          rank;
    logic                   older;
    logic [1:0]             sv;
    logic [1:0][DIST_W-1:0] sd;
  } way_t;
  typedef way_t [NUM_WAYS-1:0] row_t;

  // prior miss state
  logic [PAGE_W-1:0] prior_page_q;
  logic              prior_page_valid_q;
  logic [DIST_W-1:0] prior_dist_q;
  logic              prior_dist_valid_q;
  logic [IW-1:0]     prior_set_q;

  logic [PAGE_W-1:0] page_q;
  logic [DIST_W-1:0] dist_q;
  logic [IW-1:0]     cur_set_q, cur_set_d;
  logic [IW-1:0]     rem_q;
  logic [CW-1:0]     cnt_q;
  logic              mod_done_q;
  logic [IW-1:0]     clr_idx_q;

  logic                     in_acc, miss_acc;
  logic [NDIG-1:0][DG-1:0]  dist_ext;
  logic [XW-1:0]            mod_x, mod_r, mod_quo;
  logic [2*XW-1:0]          mod_prod;

  assign in_acc   = in_valid_i && cmd_i.in_ready;
  assign miss_acc = in_acc && !in_hit_i;
  assign dist_ext = {{(64-DIST_W){dist_q[DIST_W-1]}}, dist_q};

  // remainder by the set count, one byte of the dividend a cycle,
  // quotient estimate by reciprocal is low by at most one
  assign mod_x    = {rem_q, dist_ext[cnt_q]};
  assign mod_prod = {{XW{1'b0}}, mod_x} * {{XW{1'b0}}, RECIP};
  assign mod_quo  = mod_prod[2*XW-1:XW];
  assign mod_r    = mod_x - XW'(mod_quo * XW'(NUM_SETS));

  always_comb begin
    if (POW2) begin
      cur_set_d = dist_q[IW-1:0] & IW'(NUM_SETS - 1);
    end else if (mod_r >= XW'(NUM_SETS)) begin
      cur_set_d = IW'(mod_r - XW'(NUM_SETS));
    end else begin
      cur_set_d = IW'(mod_r);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prior_page_valid_q <= 1'b0;
      prior_dist_valid_q <= 1'b0;
      mod_done_q         <= 1'b0;
      cnt_q              <= '1;
      clr_idx_q          <= '0;
      prior_page_q       <= '0;
      prior_dist_q       <= '0;
      prior_set_q        <= '0;
    end else begin
      if (cmd_i.clr_step) clr_idx_q <= clr_idx_q + IW'(1);
      if (miss_acc) begin
        mod_done_q <= 1'b0;
        cnt_q      <= '1;
        if (!prior_page_valid_q) begin
          prior_page_q       <= in_page_i;
          prior_page_valid_q <= 1'b1;
        end
      end
      if (cmd_i.mod_step && !mod_done_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (POW2 || cnt_q == '0) mod_done_q <= 1'b1;
      end
      if ((cmd_i.look_cur && !prior_dist_valid_q) || cmd_i.look_prior) begin
        prior_page_q       <= page_q;
        prior_dist_q       <= dist_q;
        prior_set_q        <= cur_set_q;
        prior_dist_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (miss_acc) begin
      page_q <= in_page_i;
      dist_q <= {1'b0, in_page_i} - {1'b0, prior_page_q};
      rem_q  <= '0;
    end else if (cmd_i.mod_step && !mod_done_q) begin
      rem_q     <= cur_set_d;
      cur_set_q <= cur_set_d;
    end
  end

  // table memory, one row per set
  logic             ram_we, ram_re;
  logic [IW-1:0]    ram_waddr, ram_raddr;
  row_t             ram_wdata, rin, rout, rst_row;

  tdp_ram #(
    .WIDTH ($bits(row_t)),
    .DEPTH (NUM_SETS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rin)
  );

  always_comb begin
    rst_row = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      rst_row[w].rank = RW'(w);
    end
  end

  assign ram_re    = cmd_i.rd_cur || cmd_i.rd_prior;
  assign ram_raddr = cmd_i.rd_prior ? prior_set_q : cur_set_q;
  assign ram_we    = cmd_i.clr_step || cmd_i.look_cur || cmd_i.look_prior;
  assign ram_waddr = cmd_i.clr_step ? clr_idx_q : (cmd_i.look_prior ? prior_set_q : cur_set_q);
  assign ram_wdata = cmd_i.clr_step ? rst_row : rout;

  // lookup, allocation, lru update and successor training on one row
  logic [DIST_W-1:0] key;
  logic [WW-1:0]     sel;
  logic              found, free_found;
  logic [RW-1:0]     r_sel;
  logic              tr_match;
  logic              slot;

  assign key = cmd_i.look_prior ? prior_dist_q : dist_q;

  always_comb begin
    found      = 1'b0;
    free_found = 1'b0;
    sel        = '0;
    tr_match   = 1'b0;
    slot       = 1'b0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (!found && rin[w].valid && rin[w].distance == key) begin
        sel   = WW'(w);
        found = 1'b1;
      end
    end
    if (!found) begin
      for (int w = 0; w < NUM_WAYS; w++) begin
        if (!free_found && !rin[w].valid) begin
          sel        = WW'(w);
          free_found = 1'b1;
        end
      end
      if (!free_found) begin
        for (int w = 0; w < NUM_WAYS; w++) begin
          if (rin[w].rank == RW'(NUM_WAYS - 1)) sel = WW'(w);
        end
      end
    end
    r_sel = rin[sel].rank;
    rout  = rin;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (rin[w].rank < r_sel) rout[w].rank = rin[w].rank + RW'(1);
    end
    rout[sel].rank = '0;
    if (!found) begin
      rout[sel].valid    = 1'b1;
      rout[sel].distance = key;
      rout[sel].sv       = '0;
      rout[sel].sd       = '0;
      rout[sel].older    = 1'b0;
    end
    if (cmd_i.look_prior) begin
      for (int s = 0; s < 2; s++) begin
        if (!tr_match && rout[sel].sv[s] && rout[sel].sd[s] == dist_q) begin
          tr_match        = 1'b1;
          rout[sel].older = (s == 0);
        end
      end
      if (!tr_match) begin
        if (!rout[sel].sv[0])      slot = 1'b0;
        else if (!rout[sel].sv[1]) slot = 1'b1;
        else                       slot = rout[sel].older;
        rout[sel].sd[slot] = dist_q;
        rout[sel].sv[slot] = 1'b1;
        rout[sel].older    = !slot;
      end
    end
  end

  // prefetch targets from the current entry's successors
  logic [1:0][PAGE_W+1:0] tgt;
  logic [1:0]             tgt_ok;
  logic                   keep1;

  always_comb begin
    for (int s = 0; s < 2; s++) begin
      tgt[s]    = {2'b00, page_q} + {rin[sel].sd[s][DIST_W-1], rin[sel].sd[s]};
      tgt_ok[s] = found && rin[sel].sv[s] && !tgt[s][PAGE_W+1] && (tgt[s] <= MAX_PAGE)
                  && (tgt[s][PAGE_W-1:0] != page_q);
    end
    keep1 = tgt_ok[1] && !(tgt_ok[0] && tgt[0][PAGE_W-1:0] == tgt[1][PAGE_W-1:0]);
  end

  // two-entry result queue, only loaded when empty
  logic [1:0][PAGE_W-1:0] q_page_q;
  logic [1:0]             q_last_q;
  logic [1:0]             q_cnt_q;
  logic                   q_head_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_cnt_q  <= '0;
      q_head_q <= 1'b0;
    end else if (cmd_i.look_cur) begin
      q_head_q <= 1'b0;
      q_cnt_q  <= {1'b0, tgt_ok[0]} + {1'b0, keep1};
    end else if (out_valid_o && out_ready_i) begin
      q_head_q <= !q_head_q;
      q_cnt_q  <= q_cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.look_cur) begin
      if (tgt_ok[0]) begin
        q_page_q[0] <= tgt[0][PAGE_W-1:0];
        q_last_q[0] <= !keep1;
        q_page_q[1] <= tgt[1][PAGE_W-1:0];
        q_last_q[1] <= 1'b1;
      end else begin
        q_page_q[0] <= tgt[1][PAGE_W-1:0];
        q_last_q[0] <= 1'b1;
      end
    end
  end

  assign out_valid_o = (q_cnt_q != 2'd0);
  assign out_page_o  = q_page_q[q_head_q];
  assign out_last_o  = q_last_q[q_head_q];

  assign status_o.in_valid         = in_valid_i;
  assign status_o.in_hit           = in_hit_i;
  assign status_o.prior_page_valid = prior_page_valid_q;
  assign status_o.prior_dist_valid = prior_dist_valid_q;
  assign status_o.mod_done         = mod_done_q;
  assign status_o.clr_done         = (clr_idx_q == IW'(NUM_SETS - 1));
  assign status_o.q_empty          = (q_cnt_q == 2'd0);

endmodule

// ----- rtl/core/tlb_distance_prefetcher_unit.sv -----
`timescale 1ns / 1ps
// miss path: the first result of a miss appears once the results of the previous miss
//   have drained, the set index remainder is formed (one byte a cycle unless NUM_SETS is
//   a power of two) and the row of the current set is read and looked up
// acceptance: a further miss waits for the read-modify-write passes on the table memory for
//   the current and the prior set; hits and the first miss are taken every cycle while idle
// reset: asynchronous, active low; afterwards a clearing pass walks the table memory one
//   row a cycle, and no transaction is accepted until it ends
module tlb_distance_prefetcher_unit #(
  parameter int unsigned NUM_SETS         = tdp_pkg::NUM_SETS_DEF,
  parameter int unsigned NUM_WAYS         = tdp_pkg::NUM_WAYS_DEF,
  parameter int unsigned PAGE_OFFSET_BITS = tdp_pkg::PAGE_OFF_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [tdp_pkg::DATA_W-1:0] s_axis_tdata,  // [51:0] page_number
  input  logic                       s_axis_tuser,  // [0] was_hit
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [tdp_pkg::DATA_W-1:0] m_axis_tdata,  // [51:0] target_page
  output logic                       m_axis_tlast
);
  import tdp_pkg::*;

  cmd_t              cmd;
  status_t           status;
  logic [PAGE_W-1:0] out_page;

  tdp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  tdp_datapath #(
    .NUM_SETS         (NUM_SETS),
    .NUM_WAYS         (NUM_WAYS),
    .PAGE_OFFSET_BITS (PAGE_OFFSET_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_valid_i  (s_axis_tvalid),
    .in_page_i   (s_axis_tdata[PAGE_W-1:0]),
    .in_hit_i    (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_page_o  (out_page),
    .out_last_o  (m_axis_tlast)
  );

  assign s_axis_tready = cmd.in_ready;
  assign m_axis_tdata  = {{(DATA_W-PAGE_W){1'b0}}, out_page};

endmodule

// ----- rtl/core/tdp_checker.sv -----
`timescale 1ns / 1ps
module tdp_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [tdp_pkg::DATA_W-1:0] m_axis_tdata,
  input logic                       m_axis_tlast
);
  import tdp_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[DATA_W-1:PAGE_W] == '0)
    else $error("padding bits set");

  a_second_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid && m_axis_tlast)
    else $error("second result of a miss not ready");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result shown during reset");

endmodule

bind tlb_distance_prefetcher_unit tdp_checker u_tdp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
